>>> hw/rtl/pidc_pkg.sv
// Shared types and constants for the PID controller with output clamp.
`timescale 1ns / 1ps
package pidc_pkg;

  localparam int GAIN_W    = 32;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_LAST   = 3'd0,
    REG_OUT_OLDER  = 3'd1,
    REG_ERR_NOW    = 3'd2,
    REG_ERR_LAST   = 3'd3,
    REG_ERR_OLDER  = 3'd4,
    REG_DERIVATIVE = 3'd5,
    REG_SAT_MAX    = 3'd6,
    REG_SAT_MIN    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  out_last;
    logic signed [GAIN_W-1:0]  out_older;
    logic signed [GAIN_W-1:0]  err_now;
    logic signed [GAIN_W-1:0]  err_last;
    logic signed [GAIN_W-1:0]  err_older;
    logic signed [GAIN_W-1:0]  derivative;
    logic signed [DRIVE_W-1:0] sat_max;
    logic signed [DRIVE_W-1:0] sat_min;
  } coef_t;

  localparam logic signed [DRIVE_W-1:0] SAT_MAX_RESET = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] SAT_MIN_RESET = {1'b1, {(DRIVE_W-1){1'b0}}};

endpackage

>>> hw/rtl/pidc_core.sv
// Control law datapath: error, six products, sum, floor shift and clamp.
`timescale 1ns / 1ps
module pidc_core #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  pidc_pkg::coef_t                        coef,
  input  logic signed [SAMPLE_WIDTH-1:0]         sp,
  input  logic signed [SAMPLE_WIDTH-1:0]         fb,
  input  logic signed [SAMPLE_WIDTH-1:0]         fb1,
  input  logic signed [SAMPLE_WIDTH-1:0]         fb0,
  input  logic signed [SAMPLE_WIDTH:0]           e1,
  input  logic signed [SAMPLE_WIDTH:0]           e0,
  input  logic signed [pidc_pkg::DRIVE_W-1:0]    u1,
  input  logic signed [pidc_pkg::DRIVE_W-1:0]    u0,
  output logic signed [SAMPLE_WIDTH:0]           err,
  output logic signed [pidc_pkg::DRIVE_W-1:0]    drive
);
  import pidc_pkg::*;

  localparam int DIFF_W   = SAMPLE_WIDTH + 2;
  localparam int PU_W     = GAIN_W + DRIVE_W;
  localparam int PE_W     = GAIN_W + SAMPLE_WIDTH + 1;
  localparam int PD_W     = GAIN_W + DIFF_W;
  localparam int WIDE_W   = (SAMPLE_WIDTH + 36 > 50) ? SAMPLE_WIDTH + 36 : 50;
  localparam int SUM_W    = (WIDE_W > 64) ? 64 : WIDE_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PU_W-1:0]   p_u1, p_u0;
  logic signed [PE_W-1:0]   p_e2, p_e1, p_e0;
  logic signed [PD_W-1:0]   p_d;
  logic signed [WIDE_W-1:0] sum_wide;
  logic signed [SUM_W-1:0]  sum_mod;
  logic signed [SUM_W-1:0]  shifted;

  assign err  = (SAMPLE_WIDTH+1)'(sp) - (SAMPLE_WIDTH+1)'(fb);
  assign diff = DIFF_W'(fb) - (DIFF_W'(fb1) <<< 1) + DIFF_W'(fb0);

  assign p_u1 = PU_W'($signed(coef.out_last))   * PU_W'(u1);
  assign p_u0 = PU_W'($signed(coef.out_older))  * PU_W'(u0);
  assign p_e2 = PE_W'($signed(coef.err_now))    * PE_W'(err);
  assign p_e1 = PE_W'($signed(coef.err_last))   * PE_W'(e1);
  assign p_e0 = PE_W'($signed(coef.err_older))  * PE_W'(e0);
  assign p_d  = PD_W'($signed(coef.derivative)) * PD_W'(diff);

  assign sum_wide = WIDE_W'(p_u1) + WIDE_W'(p_u0) + WIDE_W'(p_e2)
                  + WIDE_W'(p_e1) + WIDE_W'(p_e0) + WIDE_W'(p_d);

  // Wrap to 64 bits at the widest sample sizes
  assign sum_mod = sum_wide[SUM_W-1:0];
  assign shifted = sum_mod >>> COEF_FRAC_BITS;

  // Upper limit wins when the limits cross
  always_comb begin
    priority if (shifted > SUM_W'(coef.sat_max)) begin
      drive = coef.sat_max;
    end else if (shifted < SUM_W'(coef.sat_min)) begin
      drive = coef.sat_min;
    end else begin
      drive = shifted[DRIVE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/pid_controller_with_clamp.sv
// Top level of the PID controller with output clamp.
//
//  port group   dir  handshake           payload
//  input        in   in_valid/in_ready   setpoint, feedback, restart
//  result       out  out_valid/out_ready drive
//  config       in   cfg_we              cfg_index, cfg_data
//
// One sample per cycle while out_ready keeps taking results: an input
// register, then the whole control law into the result register. The rate
// is set by the output feedback loop through the previous-output product.
// Synchronous reset clears gains and all histories and resets the limits to the full output range.
// A stalled result holds the result register; the input register still
// drains into it on the cycle out_ready takes the waiting transaction.
`timescale 1ns / 1ps
module pid_controller_with_clamp #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]          setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0]          feedback,
  input  logic                                    restart,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pidc_pkg::DRIVE_W-1:0]     drive,
  input  logic                                    cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pidc_pkg::GAIN_W-1:0]             cfg_data
);
  import pidc_pkg::*;

  coef_t coef;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_sp, s1_fb;
  logic                           s1_restart;

  logic signed [SAMPLE_WIDTH-1:0] fb_h1, fb_h0;
  logic signed [SAMPLE_WIDTH:0]   e_h1, e_h0;
  logic signed [DRIVE_W-1:0]      u_h1, u_h0;

  logic signed [SAMPLE_WIDTH-1:0] fb1_eff, fb0_eff;
  logic signed [SAMPLE_WIDTH:0]   e1_eff, e0_eff;
  logic signed [DRIVE_W-1:0]      u1_eff, u0_eff;

  logic signed [SAMPLE_WIDTH:0]   err;
  logic signed [DRIVE_W-1:0]      drive_next;
  logic                           s2_load;

  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  // Restart clears the histories seen by this transaction
  assign fb1_eff = s1_restart ? '0 : fb_h1;
  assign fb0_eff = s1_restart ? '0 : fb_h0;
  assign e1_eff  = s1_restart ? '0 : e_h1;
  assign e0_eff  = s1_restart ? '0 : e_h0;
  assign u1_eff  = s1_restart ? '0 : u_h1;
  assign u0_eff  = s1_restart ? '0 : u_h0;

  pidc_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .coef  (coef),
    .sp    (s1_sp),
    .fb    (s1_fb),
    .fb1   (fb1_eff),
    .fb0   (fb0_eff),
    .e1    (e1_eff),
    .e0    (e0_eff),
    .u1    (u1_eff),
    .u0    (u0_eff),
    .err   (err),
    .drive (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.out_last   <= '0;
      coef.out_older  <= '0;
      coef.err_now    <= '0;
      coef.err_last   <= '0;
      coef.err_older  <= '0;
      coef.derivative <= '0;
      coef.sat_max    <= SAT_MAX_RESET;
      coef.sat_min    <= SAT_MIN_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_OUT_LAST:   coef.out_last   <= cfg_data;
        REG_OUT_OLDER:  coef.out_older  <= cfg_data;
        REG_ERR_NOW:    coef.err_now    <= cfg_data;
        REG_ERR_LAST:   coef.err_last   <= cfg_data;
        REG_ERR_OLDER:  coef.err_older  <= cfg_data;
        REG_DERIVATIVE: coef.derivative <= cfg_data;
        REG_SAT_MAX:    coef.sat_max    <= cfg_data[DRIVE_W-1:0];
        REG_SAT_MIN:    coef.sat_min    <= cfg_data[DRIVE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_sp      <= setpoint;
      s1_fb      <= feedback;
      s1_restart <= restart;
    end
  end

  // Advance histories as each transaction moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_h1 <= '0;
      fb_h0 <= '0;
      e_h1  <= '0;
      e_h0  <= '0;
      u_h1  <= '0;
      u_h0  <= '0;
    end else if (s2_load) begin
      fb_h1 <= s1_fb;
      fb_h0 <= fb1_eff;
      e_h1  <= err;
      e_h0  <= e1_eff;
      u_h1  <= drive_next;
      u_h0  <= u1_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s2_load) begin
      drive <= drive_next;
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench for the PID controller with output clamp: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import pidc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 19;
  localparam int PHASE_ITEMS  = 100;
  localparam int FRAC_BITS    = 24;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] feedback;
    logic               restart;
  } sample_t;

  typedef struct {
    int                 sel;
    sample_t            smp;
    bit                 typed;
    logic signed [15:0] want;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [15:0]         setpoint;
  logic signed [15:0]         feedback;
  logic                       restart;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [DRIVE_W-1:0]  drive;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [GAIN_W-1:0]          cfg_data;

  // predictor state
  coef_t                      law_cfg;
  logic signed [15:0]         fb_hist[2];
  logic signed [16:0]         err_hist[2];
  logic signed [15:0]         drv_hist[2];
  logic signed [15:0]         drive_due[$];

  dir_row_t                   dir_rows[$];
  coef_t                      dir_cfg[7];
  bit                         use_typed;
  logic signed [15:0]         typed_want;
  int                         idle_pct;
  int                         stall_pct;
  bit                         quiet;
  int                         fail_count;
  int                         cycle_count;

  pid_controller_with_clamp dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .feedback  (feedback),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_history();
    for (int k = 0; k < 2; k++) begin
      fb_hist[k]  = '0;
      err_hist[k] = '0;
      drv_hist[k] = '0;
    end
  endfunction

  // One step of the control law: update histories, return the clamped drive.
  function automatic logic signed [15:0] pid_law(input logic signed [15:0] sp,
                                                 input logic signed [15:0] fb,
                                                 input logic rs);
    longint acc;
    longint err;
    longint d2;
    longint val;
    if (rs)
      clear_history();
    err = longint'(sp) - longint'(fb);
    d2  = longint'(fb) - 2 * longint'(fb_hist[1]) + longint'(fb_hist[0]);
    acc = longint'($signed(law_cfg.out_last))   * longint'(drv_hist[1])
        + longint'($signed(law_cfg.out_older))  * longint'(drv_hist[0])
        + longint'($signed(law_cfg.err_now))    * err
        + longint'($signed(law_cfg.err_last))   * longint'(err_hist[1])
        + longint'($signed(law_cfg.err_older))  * longint'(err_hist[0])
        + longint'($signed(law_cfg.derivative)) * d2;
    val = acc >>> FRAC_BITS;
    if (val > longint'($signed(law_cfg.sat_max)))
      val = longint'($signed(law_cfg.sat_max));
    else if (val < longint'($signed(law_cfg.sat_min)))
      val = longint'($signed(law_cfg.sat_min));
    fb_hist[0]  = fb_hist[1];
    fb_hist[1]  = fb;
    err_hist[0] = err_hist[1];
    err_hist[1] = 17'(err);
    drv_hist[0] = drv_hist[1];
    drv_hist[1] = 16'(val);
    return 16'(val);
  endfunction

  // Track config writes and inputs, check every drive transaction.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      law_cfg         = '0;
      law_cfg.sat_max = SAT_MAX_RESET;
      law_cfg.sat_min = SAT_MIN_RESET;
      clear_history();
    end else begin
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected drive %0d with no transaction pending", drive);
        end else begin
          want = drive_due.pop_front();
          if (drive !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("drive mismatch: expected %0d, got %0d", want, drive);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = pid_law(setpoint, feedback, restart);
        if (use_typed)
          want = typed_want;
        drive_due.push_back(want);
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_OUT_LAST:   law_cfg.out_last   = cfg_data;
          REG_OUT_OLDER:  law_cfg.out_older  = cfg_data;
          REG_ERR_NOW:    law_cfg.err_now    = cfg_data;
          REG_ERR_LAST:   law_cfg.err_last   = cfg_data;
          REG_ERR_OLDER:  law_cfg.err_older  = cfg_data;
          REG_DERIVATIVE: law_cfg.derivative = cfg_data;
          REG_SAT_MAX:    law_cfg.sat_max    = cfg_data[DRIVE_W-1:0];
          REG_SAT_MIN:    law_cfg.sat_min    = cfg_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, hold ready high when quiet.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst)
      @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic add_row(input int sel, input int sp, input int fb, input bit rs,
                         input bit typed = 1'b0, input int want = 0);
    dir_row_t row;
    row.sel          = sel;
    row.smp.setpoint = 16'(sp);
    row.smp.feedback = 16'(fb);
    row.smp.restart  = rs;
    row.typed        = typed;
    row.want         = 16'(want);
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input sample_t s);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    setpoint <= s.setpoint;
    feedback <= s.feedback;
    restart  <= s.restart;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic load_law(input coef_t c);
    logic [GAIN_W-1:0] words[8];
    words[REG_OUT_LAST]   = c.out_last;
    words[REG_OUT_OLDER]  = c.out_older;
    words[REG_ERR_NOW]    = c.err_now;
    words[REG_ERR_LAST]   = c.err_last;
    words[REG_ERR_OLDER]  = c.err_older;
    words[REG_DERIVATIVE] = c.derivative;
    // upper bits of the clamp words are don't-care; fill them with noise
    words[REG_SAT_MAX]    = {16'($urandom), c.sat_max};
    words[REG_SAT_MIN]    = {16'($urandom), c.sat_min};
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index_t'(k);
      cfg_data  <= words[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3, 4:    return 32'($urandom);
      default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic coef_t random_law();
    coef_t c;
    logic signed [15:0] a;
    logic signed [15:0] b;
    c.out_last   = pick_gain();
    c.out_older  = pick_gain();
    c.err_now    = pick_gain();
    c.err_last   = pick_gain();
    c.err_older  = pick_gain();
    c.derivative = pick_gain();
    c.sat_max    = SAT_MAX_RESET;
    c.sat_min    = SAT_MIN_RESET;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(0, 5))
      1: begin
        c.sat_max = (a > b) ? a : b;
        c.sat_min = (a > b) ? b : a;
      end
      2: begin
        // crossed limits
        c.sat_max = (a > b) ? b : a;
        c.sat_min = (a > b) ? a : b;
      end
      3: begin
        c.sat_max = a;
        c.sat_min = a;
      end
      4: begin
        c.sat_max = a;
        c.sat_min = b;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] edge_sample();
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.setpoint = 16'($urandom);
    s.feedback = 16'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        s.setpoint = edge_sample();
        s.feedback = edge_sample();
      end
      1, 2, 3: s.feedback = s.setpoint + 16'($urandom_range(0, 64)) - 16'sd32;
      4: begin
        s.setpoint = 16'($urandom_range(0, 2000)) - 16'sd1000;
        s.feedback = 16'($urandom_range(0, 2000)) - 16'sd1000;
      end
      default: ;
    endcase
    s.restart = ($urandom_range(0, 24) == 0);
    return s;
  endfunction

  initial begin
    int cur_sel;
    rst        = 1'b1;
    in_valid   = 1'b0;
    setpoint   = '0;
    feedback   = '0;
    restart    = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_OUT_LAST;
    cfg_data   = '0;
    use_typed  = 1'b0;
    typed_want = '0;
    idle_pct   = 25;
    stall_pct  = 25;
    quiet      = 1'b0;
    fail_count = 0;
    cycle_count = 0;

    for (int k = 0; k < 7; k++) begin
      dir_cfg[k]         = '0;
      dir_cfg[k].sat_max = SAT_MAX_RESET;
      dir_cfg[k].sat_min = SAT_MIN_RESET;
    end
    dir_cfg[1].err_now    = 32'sh0100_0000;
    dir_cfg[2].err_now    = 32'sh0080_0000;
    dir_cfg[3].err_now    = 32'sh0100_0000;
    dir_cfg[3].sat_max    = -16'sd100;
    dir_cfg[3].sat_min    = 16'sd100;
    dir_cfg[4].err_now    = 32'sh0100_0000;
    dir_cfg[4].sat_max    = 16'sd1000;
    dir_cfg[4].sat_min    = -16'sd1000;
    dir_cfg[5].out_last   = 32'sh0180_0000;
    dir_cfg[5].out_older  = -32'sh0080_0000;
    dir_cfg[5].err_now    = 32'sh0200_0000;
    dir_cfg[5].err_last   = -32'sh0300_0000;
    dir_cfg[5].err_older  = 32'sh0100_0000;
    dir_cfg[5].derivative = 32'sh0040_0000;
    dir_cfg[6].out_last   = 32'sh7FFF_FFFF;
    dir_cfg[6].out_older  = 32'sh8000_0000;
    dir_cfg[6].err_now    = 32'sh7FFF_FFFF;
    dir_cfg[6].err_last   = 32'sh8000_0000;
    dir_cfg[6].err_older  = 32'sh7FFF_FFFF;
    dir_cfg[6].derivative = 32'sh8000_0000;

    // zero gains after reset
    add_row(0, 32767, -32768, 1'b0, 1'b1, 0);
    add_row(0, -32768, 32767, 1'b1, 1'b1, 0);
    add_row(0, 0, 0, 1'b0, 1'b1, 0);
    // unity error gain, saturation to the output range
    add_row(1, 32767, -32768, 1'b0, 1'b1, 32767);
    add_row(1, -32768, 32767, 1'b1, 1'b1, -32768);
    add_row(1, 100, 40, 1'b0, 1'b1, 60);
    add_row(1, -1, 0, 1'b0, 1'b1, -1);
    // half gain: the shift floors toward minus infinity
    add_row(2, -1, 0, 1'b0, 1'b1, -1);
    add_row(2, 1, 0, 1'b0, 1'b1, 0);
    add_row(2, -3, 0, 1'b0, 1'b1, -2);
    // crossed limits: upper clamp wins, everything else lands on the lower one
    add_row(3, 500, 0, 1'b0, 1'b1, -100);
    add_row(3, -500, 0, 1'b0, 1'b1, 100);
    add_row(3, -100, 0, 1'b0, 1'b1, 100);
    // ordinary window
    add_row(4, 2000, 0, 1'b0, 1'b1, 1000);
    add_row(4, -2000, 0, 1'b0, 1'b1, -1000);
    add_row(4, 999, 0, 1'b0, 1'b1, 999);
    // full law with derivative and restart
    add_row(5, 1000, 200, 1'b1);
    add_row(5, 1000, 400, 1'b0);
    add_row(5, 1000, 700, 1'b0);
    add_row(5, -2000, 900, 1'b0);
    add_row(5, 0, -32768, 1'b0);
    add_row(5, 5, 5, 1'b1);
    // extreme gains
    add_row(6, 32767, -32768, 1'b1);
    add_row(6, -32768, 32767, 1'b0);
    add_row(6, 32767, 32767, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_sel = -1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sel != cur_sel) begin
        drain();
        load_law(dir_cfg[dir_rows[i].sel]);
        cur_sel = dir_rows[i].sel;
      end
      use_typed  <= dir_rows[i].typed;
      typed_want <= dir_rows[i].want;
      send_item(dir_rows[i].smp);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      load_law(random_law());
      use_typed <= 1'b0;
      idle_pct  = $urandom_range(0, 2) * 20;
      stall_pct = $urandom_range(0, 2) * 20;
      quiet     = (ph == PHASES - 1);
      repeat (PHASE_ITEMS) send_item(random_sample());
    end

    drain();
    repeat (8) @(negedge clk);
    if (drive_due.size() != 0)
      fail_count++;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
